/* src/afc_pkg.sv */
// Shared types, constants and point-field helpers for the AFC piecewise-linear mapper.
package afc_pkg;

  localparam int NUM_POINTS_DEF  = 6;   // calibration points held
  localparam int REG_COUNT       = 6;   // writable point registers
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int REQ_W           = 24;  // requested correction, hertz
  localparam int FREQ_W          = 22;  // point frequency in hertz
  localparam int DAC_W           = 16;
  localparam int UNIT_SHIFT      = 6;   // 64 Hz per frequency unit
  localparam int STEP_CNT_W      = 4;   // counts the 16 multiply / divide steps

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SEARCH,
    ST_SETUP,
    ST_MULDIV
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  // Frequency of a point in hertz: signed units of 64 Hz
  function automatic logic signed [FREQ_W-1:0] pt_freq(input logic [CFG_DATA_W-1:0] p);
    pt_freq = {p[31:16], {UNIT_SHIFT{1'b0}}};
  endfunction

  // DAC code of a point
  function automatic logic [DAC_W-1:0] pt_value(input logic [CFG_DATA_W-1:0] p);
    pt_value = p[DAC_W-1:0];
  endfunction

endpackage

/* src/afc_muldiv.sv */
// Bit-serial unsigned multiply followed by restoring divide: quot = offs * mag / width.
module afc_muldiv
  import afc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [FREQ_W-1:0]   offs,
  input  logic [FREQ_W-1:0]   width,
  input  logic [DAC_W-1:0]    mag,
  output logic                done,
  output logic [DAC_W-1:0]    quot
);

  md_state_t               state;
  md_state_t               state_next;
  logic [STEP_CNT_W-1:0]   step;
  logic [FREQ_W-1:0]       hi;      // upper product bits, later the remainder
  logic [DAC_W-1:0]        lo;      // multiplier bits, later the quotient
  logic [FREQ_W-1:0]       offs_r;
  logic [FREQ_W-1:0]       width_r;
  logic [FREQ_W:0]         sum;
  logic [FREQ_W:0]         rem_sh;
  logic                    fits;
  logic                    last_step;

  assign last_step = (step == '0);

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, offs_r} : '0);

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh = {hi, lo[DAC_W-1]};
  assign fits   = (rem_sh >= {1'b0, width_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MD_DIV) && last_step;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (go) state_next = MD_MUL;
      MD_MUL:  if (last_step) state_next = MD_DIV;
      MD_DIV:  if (last_step) state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  // Shift-add and shift-subtract datapath
  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (go) begin
          hi      <= '0;
          lo      <= mag;
          offs_r  <= offs;
          width_r <= width;
          step    <= '1;
        end
      end
      MD_MUL: begin
        {hi, lo} <= {sum, lo[DAC_W-1:1]};
        step     <= step - 1'b1;
      end
      MD_DIV: begin
        hi   <= fits ? FREQ_W'(rem_sh - {1'b0, width_r}) : rem_sh[FREQ_W-1:0];
        lo   <= {lo[DAC_W-2:0], fits};
        step <= step - 1'b1;
      end
      default: ;
    endcase
  end

  assign quot = lo;

endmodule

/* src/afc_piecewise_linear_mapper_top.sv */
// Top level of the AFC piecewise-linear mapper: config registers, clamp, segment search, interpolation.
// Sequence: accept, clamp, search the points in order, then a bit-serial multiply and divide;
//   a request at or below the first point strobes straight from the search with that point's value.
// A new request is taken only in idle, once the last one is done; the bit-serial multiply (16 steps)
//   and restoring divide (16 steps) run in turn. busy is high from accept until the strobe.
// Reset: synchronous; points and the applied correction clear to zero. Results cannot stall.
module afc_piecewise_linear_mapper_top
  import afc_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [REQ_W-1:0] requested_hz,
  output logic                    done,
  output logic [DAC_W-1:0]        dac_value,
  output logic signed [FREQ_W-1:0] applied_hz,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int PIDX_W = $clog2(NUM_POINTS);
  localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(NUM_POINTS - 1);

  state_t                   state;
  state_t                   state_next;
  logic [CFG_DATA_W-1:0]    points [NUM_POINTS];
  logic signed [REQ_W-1:0]  req_r;
  logic [PIDX_W-1:0]        cnt;
  logic signed [FREQ_W-1:0] low_f;
  logic [DAC_W-1:0]         low_v;
  logic signed [FREQ_W-1:0] up_f;
  logic [DAC_W-1:0]         up_v;
  logic                     span_neg;
  logic                     finish_now;
  logic                     md_go;
  logic                     md_done;
  logic [DAC_W-1:0]         md_quot;

  logic signed [FREQ_W-1:0] lo_f;
  logic signed [FREQ_W-1:0] hi_f;
  logic signed [FREQ_W-1:0] clamp_f;
  logic signed [FREQ_W-1:0] cur_f;
  logic [DAC_W-1:0]         cur_v;
  logic                     f_le;
  logic signed [FREQ_W:0]   offs_full;
  logic signed [FREQ_W:0]   width_full;
  logic [DAC_W:0]           span_full;
  logic [DAC_W-1:0]         span_mag;
  logic                     cfg_hit;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // Point registers; writes past the register list or the point count are dropped
  assign cfg_hit = cfg_valid && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(REG_COUNT))
                   && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(NUM_POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        points[i] <= '0;
      end
    end else if (cfg_hit) begin
      points[cfg_index[PIDX_W-1:0]] <= cfg_data;
    end
  end

  // Clamp to the first point, then to the last one
  assign lo_f = pt_freq(points[0]);
  assign hi_f = pt_freq(points[NUM_POINTS-1]);

  always_comb begin
    if (req_r < REQ_W'(lo_f)) begin
      clamp_f = (lo_f > hi_f) ? hi_f : lo_f;
    end else if (req_r > REQ_W'(hi_f)) begin
      clamp_f = hi_f;
    end else begin
      clamp_f = req_r[FREQ_W-1:0];
    end
  end

  // Point under test during the search
  assign cur_f = pt_freq(points[cnt]);
  assign cur_v = pt_value(points[cnt]);
  assign f_le  = (applied_hz <= cur_f);

  // Segment geometry; the search guarantees low_f < applied_hz <= up_f
  assign offs_full  = (FREQ_W+1)'(applied_hz) - (FREQ_W+1)'(low_f);
  assign width_full = (FREQ_W+1)'(up_f) - (FREQ_W+1)'(low_f);
  assign span_full  = {1'b0, up_v} - {1'b0, low_v};
  assign span_mag   = span_full[DAC_W] ? DAC_W'(-span_full) : span_full[DAC_W-1:0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish_now;
    end
  end

  always_comb begin
    state_next = state;
    finish_now = 1'b0;
    md_go      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (f_le) begin
          if (cnt == '0) begin
            finish_now = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SETUP;
          end
        end else if (cnt == LAST_IDX) begin
          finish_now = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: begin
        md_go      = 1'b1;
        state_next = ST_MULDIV;
      end
      ST_MULDIV: begin
        if (md_done) begin
          finish_now = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Applied correction doubles as the clamped request used by the search
  always_ff @(posedge clk) begin
    if (rst) begin
      applied_hz <= '0;
    end else if (state == ST_CLAMP) begin
      applied_hz <= clamp_f;
    end
  end

  // Capture, search and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_r <= requested_hz;
          cnt   <= '0;
        end
      end
      ST_CLAMP: ;
      ST_SEARCH: begin
        if (f_le) begin
          up_f <= cur_f;
          up_v <= cur_v;
          if (cnt == '0) dac_value <= cur_v;
        end else begin
          low_f <= cur_f;
          low_v <= cur_v;
          if (cnt == LAST_IDX) begin
            dac_value <= cur_v;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      ST_SETUP: begin
        span_neg <= span_full[DAC_W];
      end
      ST_MULDIV: begin
        if (md_done) dac_value <= span_neg ? (low_v - md_quot) : (low_v + md_quot);
      end
      default: ;
    endcase
  end

  afc_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .go    (md_go),
    .offs  (offs_full[FREQ_W-1:0]),
    .width (width_full[FREQ_W-1:0]),
    .mag   (span_mag),
    .done  (md_done),
    .quot  (md_quot)
  );

  // A result strobe only ends a request in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // An accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The applied correction moves only in the clamp cycle
  a_applied_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(applied_hz)) |-> ($past(state) == ST_CLAMP))
    else $error("applied correction changed outside the clamp cycle");

  // The divider finishes only while the sequencer waits for it
  a_md_done_state: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == ST_MULDIV))
    else $error("divider finished outside the wait state");

  // The search never runs past the last point
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (cnt <= LAST_IDX))
    else $error("search index beyond the last point");

endmodule
